// ===== design/sht_pkg.sv =====
// shared types and constants of the slot handle table
package sht_pkg;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned LIMIT_W = 4;

  // load limit after reset
  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 4'd12;

  // depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_DELETE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // one classified request
  typedef struct packed {
    action_e         action;
    logic [ID_W-1:0] key;
    logic [ID_W-1:0] payload;
  } cmd_t;

  // one result transaction
  typedef struct packed {
    status_e         status;
    logic [ID_W-1:0] assigned_id;
    logic [ID_W-1:0] payload_out;
  } res_t;

endpackage

// ===== design/sht_ram.sv =====
// generic single write port, single read port ram with registered read
module sht_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/sht_front.sv =====
// request front end: accepts transactions and reduces the key to a slot index
module sht_front import sht_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     init_busy_i,
  input  logic                     s_valid_i,
  output logic                     s_ready_o,
  input  logic [1:0]               s_user_i,
  input  logic [2*ID_W-1:0]        s_data_i,
  output logic                     cmd_valid_o,
  input  logic                     cmd_ready_i,
  output cmd_t                     cmd_o,
  output logic [$clog2(SLOTS)-1:0] cmd_slot_o
);

  localparam int unsigned IW   = $clog2(SLOTS);
  localparam bit          POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  // floor of log2 of SLOTS, sets the reciprocal scale
  localparam int unsigned FL   = $clog2(SLOTS + 1) - 1;
  localparam logic [2*ID_W-1:0] RECIP_FULL = ((2*ID_W)'(1) << (ID_W + FL)) / SLOTS;
  localparam logic [ID_W-1:0]   RECIP      = RECIP_FULL[ID_W-1:0];

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_RED
  } fstate_e;

  fstate_e           state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic              cmd_valid_q, cmd_valid_d;
  logic [IW-1:0]     slot_q, slot_d;
  logic [2*ID_W-1:0] prod_q, prod_d;
  logic [IW:0]       quot_lo;
  logic [IW:0]       rem_raw;
  logic [IW:0]       rem_fix;
  cmd_t              in_cmd;
  logic              accept;

  assign in_cmd.action  = action_e'(s_user_i);
  assign in_cmd.key     = s_data_i[ID_W-1:0];
  assign in_cmd.payload = s_data_i[2*ID_W-1:ID_W];

  assign s_ready_o = !init_busy_i && (state_q == F_IDLE) && (!cmd_valid_q || cmd_ready_i);
  assign accept    = s_valid_i && s_ready_o;

  // key mod SLOTS: the reciprocal quotient is low by at most one,
  // so the raw remainder is below 2*SLOTS and one subtract corrects it
  assign quot_lo = prod_q[ID_W+FL +: IW+1];
  assign rem_raw = cmd_q.key[IW:0] - quot_lo * (IW+1)'(SLOTS);
  assign rem_fix = (rem_raw >= (IW+1)'(SLOTS)) ? rem_raw - (IW+1)'(SLOTS) : rem_raw;

  // next state
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cmd_valid_d = cmd_valid_q;
    slot_d      = slot_q;
    prod_d      = prod_q;
    if (cmd_valid_q && cmd_ready_i) begin
      cmd_valid_d = 1'b0;
    end
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          cmd_d = in_cmd;
          if (POW2 || in_cmd.action == ACT_ADD) begin
            slot_d      = in_cmd.key[IW-1:0];
            cmd_valid_d = 1'b1;
          end else begin
            state_d = F_MUL;
          end
        end
      end
      F_MUL: begin
        // 32 by 32 multiply by the scaled reciprocal
        prod_d  = {ID_W'(0), cmd_q.key} * {ID_W'(0), RECIP};
        state_d = F_RED;
      end
      F_RED: begin
        slot_d      = rem_fix[IW-1:0];
        cmd_valid_d = 1'b1;
        state_d     = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      cmd_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_valid_q <= cmd_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    slot_q <= slot_d;
    prod_q <= prod_d;
  end

  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;
  assign cmd_slot_o  = slot_q;

endmodule

// ===== design/sht_fifo.sv =====
// short register queue between front and back
module sht_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] fifo_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    count_q;
  logic             push, pop;

  assign in_ready_o  = (count_q != CW'(DEPTH));
  assign out_valid_o = (count_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = fifo_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= in_data_i;
    end
  end

endmodule

// ===== design/sht_back.sv =====
// table engine: clears valid bits, probes and updates slots, holds the result
module sht_back import sht_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [LIMIT_W-1:0]       load_limit_i,
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  input  cmd_t                     cmd_i,
  input  logic [$clog2(SLOTS)-1:0] cmd_slot_i,
  output logic                     init_busy_o,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output res_t                     res_o
);

  localparam int unsigned IW   = $clog2(SLOTS);
  localparam int unsigned CW   = $clog2(SLOTS + 1);
  localparam int unsigned CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

  typedef enum logic [1:0] {
    B_INIT,
    B_IDLE,
    B_CHECK
  } bstate_e;

  bstate_e         state_q, state_d;
  logic [IW-1:0]   clr_q, clr_d;
  logic [CW-1:0]   live_q, live_d;
  logic [ID_W-1:0] id_ctr_q, id_ctr_d;
  logic [IW-1:0]   ctr_slot_q, ctr_slot_d;
  logic [ID_W-1:0] probe_id_q, probe_id_d;
  logic [IW-1:0]   probe_slot_q, probe_slot_d;
  logic [IW:0]     steps_q, steps_d;
  action_e         act_q, act_d;
  logic [ID_W-1:0] key_q, key_d;
  logic [ID_W-1:0] pay_q, pay_d;
  logic            out_valid_q, out_valid_d;
  res_t            res_q, res_d;

  logic            v_we, t_we;
  logic [IW-1:0]   waddr, raddr;
  logic            v_wdata, v_rdata;
  logic [2*ID_W-1:0] t_rdata;
  logic [IW-1:0]   nxt_slot;
  logic            hit;
  logic            too_full;

  // valid bits, cleared by a sweep after reset
  sht_ram #(
    .WIDTH(1),
    .DEPTH(SLOTS)
  ) u_valid_ram (
    .clk_i  (clk_i),
    .we_i   (v_we),
    .waddr_i(waddr),
    .wdata_i(v_wdata),
    .raddr_i(raddr),
    .rdata_o(v_rdata)
  );

  // stored id and payload of each slot
  sht_ram #(
    .WIDTH(2*ID_W),
    .DEPTH(SLOTS)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (t_we),
    .waddr_i(waddr),
    .wdata_i({probe_id_q, pay_q}),
    .raddr_i(raddr),
    .rdata_o(t_rdata)
  );

  assign too_full = (CMPW'(live_q) > CMPW'(load_limit_i)) || (live_q >= CW'(SLOTS));
  assign hit      = v_rdata && (t_rdata[2*ID_W-1:ID_W] == key_q);

  // slot of the next id, following the counter wrap as well
  assign nxt_slot = ((probe_id_q == '1) || (probe_slot_q == IW'(SLOTS - 1))) ? '0 :
                    probe_slot_q + IW'(1);

  // next state and slot accesses
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    live_d       = live_q;
    id_ctr_d     = id_ctr_q;
    ctr_slot_d   = ctr_slot_q;
    probe_id_d   = probe_id_q;
    probe_slot_d = probe_slot_q;
    steps_d      = steps_q;
    act_d        = act_q;
    key_d        = key_q;
    pay_d        = pay_q;
    out_valid_d  = out_valid_q;
    res_d        = res_q;
    cmd_ready_o  = 1'b0;
    v_we         = 1'b0;
    t_we         = 1'b0;
    v_wdata      = 1'b0;
    waddr        = probe_slot_q;
    raddr        = probe_slot_q;
    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      B_INIT: begin
        v_we  = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + IW'(1);
        if (clr_q == IW'(SLOTS - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (cmd_valid_i && (!out_valid_q || m_ready_i)) begin
          cmd_ready_o = 1'b1;
          act_d       = cmd_i.action;
          key_d       = cmd_i.key;
          pay_d       = cmd_i.payload;
          steps_d     = '0;
          res_d       = '{status: ST_NOT_FOUND, assigned_id: '0, payload_out: '0};
          unique case (cmd_i.action)
            ACT_ADD: begin
              if (too_full) begin
                res_d.status = ST_FULL;
                out_valid_d  = 1'b1;
              end else begin
                probe_id_d   = id_ctr_q;
                probe_slot_d = ctr_slot_q;
                raddr        = ctr_slot_q;
                state_d      = B_CHECK;
              end
            end
            ACT_LOOKUP, ACT_DELETE: begin
              probe_slot_d = cmd_slot_i;
              raddr        = cmd_slot_i;
              state_d      = B_CHECK;
            end
            default: out_valid_d = 1'b1;
          endcase
        end
      end
      B_CHECK: begin
        unique case (act_q)
          ACT_ADD: begin
            if (!v_rdata) begin
              // free slot: fill it and move the id counter onto it
              v_we              = 1'b1;
              v_wdata           = 1'b1;
              t_we              = 1'b1;
              id_ctr_d          = probe_id_q;
              ctr_slot_d        = probe_slot_q;
              live_d            = live_q + CW'(1);
              res_d.status      = ST_OK;
              res_d.assigned_id = probe_id_q;
              out_valid_d       = 1'b1;
              state_d           = B_IDLE;
            end else if (steps_q == (IW+1)'(SLOTS)) begin
              res_d.status = ST_FULL;
              out_valid_d  = 1'b1;
              state_d      = B_IDLE;
            end else begin
              probe_id_d   = probe_id_q + ID_W'(1);
              probe_slot_d = nxt_slot;
              raddr        = nxt_slot;
              steps_d      = steps_q + (IW+1)'(1);
            end
          end
          ACT_LOOKUP: begin
            if (hit) begin
              res_d.status      = ST_OK;
              res_d.payload_out = t_rdata[ID_W-1:0];
            end
            out_valid_d = 1'b1;
            state_d     = B_IDLE;
          end
          ACT_DELETE: begin
            if (hit) begin
              v_we         = 1'b1;
              res_d.status = ST_OK;
              if (live_q != '0) begin
                live_d = live_q - CW'(1);
              end
            end
            out_valid_d = 1'b1;
            state_d     = B_IDLE;
          end
          default: begin
            out_valid_d = 1'b1;
            state_d     = B_IDLE;
          end
        endcase
      end
      default: state_d = B_IDLE;
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_INIT;
      clr_q       <= '0;
      live_q      <= '0;
      id_ctr_q    <= '0;
      ctr_slot_q  <= '0;
      steps_q     <= '0;
      act_q       <= ACT_LOOKUP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      live_q      <= live_d;
      id_ctr_q    <= id_ctr_d;
      ctr_slot_q  <= ctr_slot_d;
      steps_q     <= steps_d;
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    probe_id_q   <= probe_id_d;
    probe_slot_q <= probe_slot_d;
    key_q        <= key_d;
    pay_q        <= pay_d;
    res_q        <= res_d;
  end

  assign init_busy_o = (state_q == B_INIT);
  assign m_valid_o   = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/slot_handle_table.sv =====
// slot handle table top level: front end, command queue and table engine
//
//  channel   dir  handshake                        content
//  s_axis    in   s_axis_tvalid_i / s_axis_tready_o  request: action, key id, payload
//  m_axis    out  m_axis_tvalid_o / m_axis_tready_i  result: status, assigned id, payload
//  cfg       in   cfg_valid_i / cfg_ready_o          load limit register write
//
// in the table engine a lookup or delete reads its slot, then checks and updates it.
// an add reads the slot at the id counter, steps over occupied slots to a free one or
// reports full; the slot ram's single read port gives one probe per cycle.
// a refused add skips the probe. if SLOTS is not a power of two a lookup or delete also
// passes front end states F_MUL and F_RED: a reciprocal multiply, then a correcting subtract.
// after reset a clearing pass zeroes every valid bit; s_axis_tready_o is low
// meanwhile. while a result waits on m_axis_tready_i the queue fills up to its depth.
module slot_handle_table import sht_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [2*ID_W-1:0]  s_axis_tdata_i,   // key_id [31:0], payload_in [63:32]
  input  logic [1:0]         s_axis_tuser_i,   // action [1:0]
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [2*ID_W-1:0]  m_axis_tdata_o,   // assigned_id [31:0], payload_out [63:32]
  output logic [1:0]         m_axis_tuser_o,   // status [1:0]
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [LIMIT_W-1:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned QW = $bits(cmd_t) + IW;

  logic               init_busy;
  logic               f_valid, f_ready;
  cmd_t               f_cmd;
  logic [IW-1:0]      f_slot;
  logic               q_valid, q_ready;
  logic [QW-1:0]      q_data;
  logic [LIMIT_W-1:0] load_limit_q;
  res_t               res;

  // load limit register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_limit_q <= LOAD_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      load_limit_q <= cfg_data_i;
    end
  end

  sht_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_busy_i(init_busy),
    .s_valid_i  (s_axis_tvalid_i),
    .s_ready_o  (s_axis_tready_o),
    .s_user_i   (s_axis_tuser_i),
    .s_data_i   (s_axis_tdata_i),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_o      (f_cmd),
    .cmd_slot_o (f_slot)
  );

  sht_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (f_valid),
    .in_ready_o (f_ready),
    .in_data_i  ({f_slot, f_cmd}),
    .out_valid_o(q_valid),
    .out_ready_i(q_ready),
    .out_data_o (q_data)
  );

  sht_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_limit_i(load_limit_q),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (cmd_t'(q_data[$bits(cmd_t)-1:0])),
    .cmd_slot_i  (q_data[QW-1:$bits(cmd_t)]),
    .init_busy_o (init_busy),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tuser_o = res.status;
  assign m_axis_tdata_o = {res.payload_out, res.assigned_id};

endmodule

// ===== design/sht_checker.sv =====
// port level checker for the slot handle table and its bind
module sht_checker import sht_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == ST_OK || m_axis_tuser_o == ST_NOT_FOUND
      || m_axis_tuser_o == ST_FULL))
    else $error("undefined status code");

  // a refused or missed request carries zero data
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ST_OK |-> m_axis_tdata_o == 64'd0)
    else $error("failed request with nonzero data");

  // a lookup payload and an assigned id never appear together
  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[63:32] != 32'd0 |-> m_axis_tdata_o[31:0] == 32'd0)
    else $error("assigned id and payload both set");

  // leaving reset: no result and no intake where reset rises, as the clearing pass starts
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o && !s_axis_tready_o)
    else $error("activity right after reset");

endmodule

bind slot_handle_table sht_checker u_sht_checker (.*);

// ===== bench/slot_handle_table_tb.sv =====
// testbench for the slot handle table: streamed requests checked against a predicted table
`timescale 1ns / 1ps

module slot_handle_table_tb;
  import sht_pkg::*;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned SETTLE_CYC  = 2 * SLOTS + 8;
  localparam int unsigned HOLD_CYC    = 120;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned NUM_PHASES  = 7;

  // code outside the action enum, answered with not found
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // predicted table contents and the results still owed by the block
  class handle_table_scoreboard;
    logic                   slot_used[SLOTS];
    logic [ID_W-1:0]        slot_id[SLOTS];
    logic [ID_W-1:0]        slot_handle[SLOTS];
    logic [ID_W-1:0]        next_id;
    int unsigned            live;
    logic [LIMIT_W-1:0]     limit;
    res_t                   expected_results[$];
    int unsigned            fail_count;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_id[i] = '0;
        slot_handle[i] = '0;
      end
      next_id = '0;
      live = 0;
      limit = LOAD_LIMIT_RST;
      fail_count = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      limit = value;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // pick the id of a random live entry, if any
    function bit pick_live(output logic [ID_W-1:0] id);
      int unsigned start;
      int unsigned s;
      start = $urandom_range(SLOTS - 1, 0);
      id = '0;
      for (int i = 0; i < SLOTS; i++) begin
        s = (start + i) % SLOTS;
        if (slot_used[s]) begin
          id = slot_id[s];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // update the table for an accepted request and queue its result
    function void note_request(logic [1:0] act, logic [ID_W-1:0] key, logic [ID_W-1:0] pay);
      res_t            r;
      logic [ID_W-1:0] probe;
      int unsigned     steps;
      int unsigned     s;
      r.status      = ST_NOT_FOUND;
      r.assigned_id = '0;
      r.payload_out = '0;
      s = key % SLOTS;
      case (act)
        ACT_ADD: begin
          if (live > limit || live >= SLOTS) begin
            r.status = ST_FULL;
          end else begin
            probe = next_id;
            steps = 0;
            while (slot_used[probe % SLOTS] && steps < SLOTS) begin
              probe = probe + 1;
              steps++;
            end
            if (slot_used[probe % SLOTS]) begin
              r.status = ST_FULL;
            end else begin
              next_id = probe;
              slot_used[probe % SLOTS] = 1'b1;
              slot_id[probe % SLOTS] = probe;
              slot_handle[probe % SLOTS] = pay;
              live = (live + 1) & 5'h1f;
              r.status = ST_OK;
              r.assigned_id = probe;
            end
          end
        end
        ACT_LOOKUP: begin
          if (slot_used[s] && slot_id[s] == key) begin
            r.status = ST_OK;
            r.payload_out = slot_handle[s];
          end
        end
        ACT_DELETE: begin
          if (slot_used[s] && slot_id[s] == key) begin
            slot_used[s] = 1'b0;
            if (live > 0) live--;
            r.status = ST_OK;
          end
        end
        default: begin
        end
      endcase
      expected_results.insert(expected_results.size(), r);
    endfunction

    // compare one result transaction with the oldest expectation
    function void check_result(res_t got);
      res_t exp_r;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d id %h payload %h",
                 $time, got.status, got.assigned_id, got.payload_out);
        fail_count++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.status !== exp_r.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, exp_r.status, got.status);
        fail_count++;
      end
      if (got.assigned_id !== exp_r.assigned_id) begin
        $display("%0t: assigned id mismatch, expected %h actual %h",
                 $time, exp_r.assigned_id, got.assigned_id);
        fail_count++;
      end
      if (got.payload_out !== exp_r.payload_out) begin
        $display("%0t: payload mismatch, expected %h actual %h",
                 $time, exp_r.payload_out, got.payload_out);
        fail_count++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [2*ID_W-1:0]  s_axis_tdata = '0;   // key_id [31:0], payload_in [63:32]
  logic [1:0]         s_axis_tuser = '0;   // action [1:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [2*ID_W-1:0]  m_axis_tdata;        // assigned_id [31:0], payload_out [63:32]
  logic [1:0]         m_axis_tuser;        // status [1:0]
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;

  handle_table_scoreboard sb = new();
  bit                     rx_hold_req = 1'b0;
  int unsigned            burst_left = 0;

  slot_handle_table #(.SLOTS(SLOTS)) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result monitor
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status      = status_e'(m_axis_tuser);
      got.assigned_id = m_axis_tdata[ID_W-1:0];
      got.payload_out = m_axis_tdata[2*ID_W-1:ID_W];
      sb.check_result(got);
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned len;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        @(posedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
      end
      mode = $urandom_range(3, 0);
      len  = $urandom_range(64, 4);
      repeat (len) begin
        @(posedge clk_i);
        case (mode)
          0, 1: m_axis_tready <= 1'b1;
          2:    m_axis_tready <= ($urandom_range(1, 0) == 1);
          default: m_axis_tready <= ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  // offer one request and wait for its transaction
  task automatic send_request(logic [1:0] act, logic [ID_W-1:0] key, logic [ID_W-1:0] pay);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {pay, key};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(act, key, pay);
  endtask

  // bursts of random length, separated by random gaps or none
  task automatic sender_gap();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(32, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // stop sending until every result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // load limit write, only with the block idle
  task automatic write_limit(logic [LIMIT_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_limit(value);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // random request: adds, ops on live ids, aliased ids, random ids and the unused code
  task automatic send_random(int unsigned add_pct);
    logic [1:0]      act;
    logic [ID_W-1:0] key;
    logic [ID_W-1:0] pay;
    int unsigned     pick;
    key  = $urandom;
    pay  = $urandom;
    pick = $urandom_range(99, 0);
    if (pick < add_pct) begin
      act = ACT_ADD;
    end else if ($urandom_range(99, 0) < 6) begin
      act = ACT_UNUSED;
    end else begin
      act  = ($urandom_range(1, 0) == 1) ? ACT_LOOKUP : ACT_DELETE;
      pick = $urandom_range(99, 0);
      if (pick < 65) begin
        void'(sb.pick_live(key));
      end else if (pick < 80) begin
        if (sb.pick_live(key)) key = key + (ID_W'($urandom_range(4095, 1)) << 4);
      end
    end
    send_request(act, key, pay);
  endtask

  // stimulus
  initial begin
    logic [LIMIT_W-1:0] phase_limit[NUM_PHASES];
    int unsigned        phase_add[NUM_PHASES];
    phase_limit = '{4'd15, 4'd0, 4'd9, 4'd15, 4'd5, 4'd1, 4'd12};
    phase_add   = '{60, 40, 45, 50, 40, 35, 45};
    phase_limit[4] = $urandom_range(14, 2);

    // reset
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, probing, aliases, misses and the unused code
    send_request(ACT_ADD, 32'h0, 32'h0);
    send_request(ACT_ADD, 32'hffff_ffff, 32'hffff_ffff);
    send_request(ACT_LOOKUP, 32'h0, 32'hffff_ffff);
    send_request(ACT_LOOKUP, 32'h1, 32'h0);
    send_request(ACT_LOOKUP, 32'h10, 32'h0);
    send_request(ACT_LOOKUP, 32'hffff_ffff, 32'h0);
    send_request(ACT_DELETE, 32'hffff_fff1, 32'h0);
    send_request(ACT_DELETE, 32'h0, 32'h0);
    send_request(ACT_DELETE, 32'h0, 32'hffff_ffff);
    send_request(ACT_LOOKUP, 32'h0, 32'h0);
    send_request(ACT_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    send_request(ACT_UNUSED, 32'h0, 32'h0);
    send_request(ACT_ADD, 32'h0, 32'h5a5a_a5a5);
    write_limit(4'd2);
    send_request(ACT_ADD, 32'h0, 32'h1234_5678);
    send_request(ACT_ADD, 32'h0, 32'h8765_4321);
    send_request(ACT_LOOKUP, 32'h3, 32'h0);
    send_request(ACT_DELETE, 32'h3, 32'h0);
    send_request(ACT_ADD, 32'h0, 32'hdead_beef);
    send_request(ACT_LOOKUP, 32'h3, 32'h0);

    // random phases over several load limits
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_limit(phase_limit[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == 40) begin
          // receiver holds off while requests keep coming
          rx_hold_req = 1'b1;
          repeat (30) send_random(phase_add[p]);
        end
        if (p == 2 && i == 100) drain_results();
        send_random(phase_add[p]);
        sender_gap();
      end
    end

    // wind down
    drain_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
